/* rtl/imhdk_pkg.sv */
`timescale 1ns / 1ps

package imhdk_pkg;

  // sizes fixed by the stream fields
  localparam int unsigned ID_W       = 10;
  localparam int unsigned KEY_IO_W   = 32;
  localparam int unsigned CFG_W      = 11;
  localparam int unsigned IN_DATA_W  = 48;
  localparam int unsigned OUT_DATA_W = 48;

  // defaults for the top level parameters
  localparam int unsigned HEAP_DEPTH_DEF = 1024;
  localparam int unsigned KEY_BITS_DEF   = 32;

  // heap_size after reset
  localparam logic [CFG_W-1:0] HEAP_SIZE_RST = 11'd1024;

  // request kinds carried in tuser
  localparam logic REQ_UPDATE = 1'b0;
  localparam logic REQ_INIT   = 1'b1;

  typedef struct packed {
    logic                init;
    logic [ID_W-1:0]     point_id;
    logic [KEY_IO_W-1:0] new_key;
  } heap_req_t;

  typedef struct packed {
    logic                bad;
    logic [ID_W-1:0]     top_id;
    logic [KEY_IO_W-1:0] top_key;
  } heap_res_t;

endpackage

/* rtl/imhdk_ram.sv */
`timescale 1ns / 1ps

module imhdk_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 1024
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

/* rtl/imhdk_ctrl.sv */
`timescale 1ns / 1ps

module imhdk_ctrl #(
  parameter int unsigned HEAP_DEPTH = 1024,
  parameter int unsigned KEY_BITS   = 32
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic [imhdk_pkg::CFG_W-1:0]   heap_size_i,
  input  logic                          req_valid_i,
  output logic                          req_ready_o,
  input  imhdk_pkg::heap_req_t          req_i,
  output logic                          res_valid_o,
  input  logic                          res_ready_i,
  output imhdk_pkg::heap_res_t          res_o,
  // slot key memory
  output logic                          key_we_o,
  output logic [$clog2(HEAP_DEPTH)-1:0] key_waddr_o,
  output logic [KEY_BITS-1:0]           key_wdata_o,
  input  logic [KEY_BITS-1:0]           key_rdata_i,
  // slot point memory
  output logic                          sp_we_o,
  output logic [$clog2(HEAP_DEPTH)-1:0] sp_waddr_o,
  output logic [$clog2(HEAP_DEPTH)-1:0] sp_wdata_o,
  input  logic [$clog2(HEAP_DEPTH)-1:0] sp_rdata_i,
  // shared read address of key and slot point memories
  output logic [$clog2(HEAP_DEPTH)-1:0] slot_raddr_o,
  // point slot memory
  output logic                          ps_we_o,
  output logic [$clog2(HEAP_DEPTH)-1:0] ps_waddr_o,
  output logic [$clog2(HEAP_DEPTH)-1:0] ps_wdata_o,
  output logic [$clog2(HEAP_DEPTH)-1:0] ps_raddr_o,
  input  logic [$clog2(HEAP_DEPTH)-1:0] ps_rdata_i
);

  import imhdk_pkg::*;

  localparam int unsigned SW = $clog2(HEAP_DEPTH);
  localparam int unsigned CW = $clog2(HEAP_DEPTH + 1);
  localparam int unsigned XW = SW + 2;
  localparam logic [KEY_BITS-1:0] KEY_INF = {KEY_BITS{1'b1}};

  typedef enum logic [8:0] {
    S_CLEAR = 9'b000000001,
    S_IDLE  = 9'b000000010,
    S_FILL  = 9'b000000100,
    S_LOOK  = 9'b000001000,
    S_POS   = 9'b000010000,
    S_RDR   = 9'b000100000,
    S_CMP   = 9'b001000000,
    S_FINAL = 9'b010000000,
    S_DONE  = 9'b100000000
  } state_e;

  state_e            state_q, state_d;
  logic [CW-1:0]     n_q, n_d;
  logic [SW-1:0]     cnt_q, cnt_d;
  logic [SW-1:0]     p_q, p_d;
  logic [SW-1:0]     pt_q, pt_d;
  logic [KEY_BITS-1:0] key_q, key_d;
  logic [KEY_BITS-1:0] lkey_q, lkey_d;
  logic [SW-1:0]     lpt_q, lpt_d;
  logic              moved_q, moved_d;
  logic              bad_q, bad_d;
  logic [KEY_BITS-1:0] top_key_q;
  logic [SW-1:0]     top_pt_q;

  logic [CW-1:0]     live_n;
  logic [XW-1:0]     n_x, left_x, right_x, nleft_x;
  logic              right_ok, pick_right;
  logic [KEY_BITS-1:0] ckey;
  logic [SW-1:0]     cpt, caddr;
  logic              fill_last;

  // heap_size saturated into one .. depth
  always_comb begin
    if (heap_size_i == '0) begin
      live_n = CW'(1);
    end else if (32'(heap_size_i) > 32'(HEAP_DEPTH)) begin
      live_n = CW'(HEAP_DEPTH);
    end else begin
      live_n = CW'(heap_size_i);
    end
  end

  assign n_x       = XW'(n_q);
  assign left_x    = (XW'(p_q) << 1) + XW'(1);
  assign right_x   = left_x + XW'(1);
  assign right_ok  = right_x < n_x;
  assign pick_right = right_ok && !(lkey_q > key_rdata_i);
  assign ckey      = pick_right ? key_rdata_i : lkey_q;
  assign cpt       = pick_right ? sp_rdata_i : lpt_q;
  assign caddr     = pick_right ? SW'(right_x) : SW'(left_x);
  assign nleft_x   = (XW'(caddr) << 1) + XW'(1);
  assign fill_last = (CW'(cnt_q) + CW'(1)) == n_q;

  always_comb begin
    state_d = state_q;
    n_d     = n_q;
    cnt_d   = cnt_q;
    p_d     = p_q;
    pt_d    = pt_q;
    key_d   = key_q;
    lkey_d  = lkey_q;
    lpt_d   = lpt_q;
    moved_d = moved_q;
    bad_d   = bad_q;

    key_we_o     = 1'b0;
    key_waddr_o  = p_q;
    key_wdata_o  = key_q;
    sp_we_o      = 1'b0;
    sp_waddr_o   = p_q;
    sp_wdata_o   = pt_q;
    ps_we_o      = 1'b0;
    ps_waddr_o   = pt_q;
    ps_wdata_o   = p_q;
    slot_raddr_o = SW'(left_x);
    ps_raddr_o   = SW'(req_i.point_id);

    req_ready_o = 1'b0;
    res_valid_o = 1'b0;

    unique case (state_q) inside
      S_CLEAR, S_FILL: begin
        key_we_o    = 1'b1;
        key_waddr_o = cnt_q;
        key_wdata_o = KEY_INF;
        sp_we_o     = 1'b1;
        sp_waddr_o  = cnt_q;
        sp_wdata_o  = cnt_q;
        ps_we_o     = 1'b1;
        ps_waddr_o  = cnt_q;
        ps_wdata_o  = cnt_q;
        cnt_d       = cnt_q + SW'(1);
        if (fill_last) begin
          state_d = (state_q == S_CLEAR) ? S_IDLE : S_DONE;
        end
      end
      S_IDLE: begin
        req_ready_o = 1'b1;
        if (req_valid_i) begin
          n_d     = live_n;
          key_d   = KEY_BITS'(req_i.new_key);
          bad_d   = 1'b0;
          moved_d = 1'b0;
          cnt_d   = '0;
          if (req_i.init == REQ_INIT) begin
            state_d = S_FILL;
          end else if (32'(req_i.point_id) >= 32'(live_n)) begin
            bad_d   = 1'b1;
            state_d = S_DONE;
          end else begin
            state_d = S_LOOK;
          end
        end
      end
      S_LOOK: begin
        // slot of the point is back, fetch the point held there
        p_d          = ps_rdata_i;
        slot_raddr_o = ps_rdata_i;
        state_d      = S_POS;
      end
      S_POS: begin
        pt_d = sp_rdata_i;
        if (left_x >= n_x) begin
          state_d = S_FINAL;
        end else begin
          state_d = S_RDR;
        end
      end
      S_RDR: begin
        lkey_d       = key_rdata_i;
        lpt_d        = sp_rdata_i;
        slot_raddr_o = SW'(right_x);
        state_d      = S_CMP;
      end
      S_CMP: begin
        slot_raddr_o = SW'(nleft_x);
        if (key_q < ckey) begin
          // child moves up into the current slot
          key_we_o   = 1'b1;
          key_wdata_o = ckey;
          sp_we_o    = 1'b1;
          sp_wdata_o = cpt;
          ps_we_o    = 1'b1;
          ps_waddr_o = cpt;
          ps_wdata_o = p_q;
          p_d        = caddr;
          moved_d    = 1'b1;
          state_d    = (nleft_x >= n_x) ? S_FINAL : S_RDR;
        end else begin
          state_d = S_FINAL;
        end
      end
      S_FINAL: begin
        key_we_o = 1'b1;
        sp_we_o  = moved_q;
        ps_we_o  = moved_q;
        state_d  = S_DONE;
      end
      S_DONE: begin
        res_valid_o = 1'b1;
        if (res_ready_i) begin
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  assign res_o.bad     = bad_q;
  assign res_o.top_id  = ID_W'(top_pt_q);
  assign res_o.top_key = KEY_IO_W'(top_key_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_CLEAR;
      n_q       <= CW'(HEAP_DEPTH);
      cnt_q     <= '0;
      moved_q   <= 1'b0;
      bad_q     <= 1'b0;
      top_key_q <= KEY_INF;
      top_pt_q  <= '0;
    end else begin
      state_q <= state_d;
      n_q     <= n_d;
      cnt_q   <= cnt_d;
      moved_q <= moved_d;
      bad_q   <= bad_d;
      // copy of slot zero, kept in step with its writes
      if (key_we_o && key_waddr_o == '0) begin
        top_key_q <= key_wdata_o;
      end
      if (sp_we_o && sp_waddr_o == '0) begin
        top_pt_q <= sp_wdata_o;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    p_q    <= p_d;
    pt_q   <= pt_d;
    key_q  <= key_d;
    lkey_q <= lkey_d;
    lpt_q  <= lpt_d;
  end

endmodule

/* rtl/indexed_max_heap_decrease_key_unit.sv */
`timescale 1ns / 1ps

// channel   dir  payload (from bit 0 up)                         handshake
// s_axis    in   tdata: point_id[9:0] new_key[41:10], zero pad   tvalid/tready
//                tuser: req_type (0 update key, 1 reinit heap)
// m_axis    out  tdata: top_id[9:0] top_key[41:10], zero pad     tvalid/tready
//                tuser: bad_request
// cfg       in   cfg_wdata_i: heap_size                          cfg_we_i, no wait
//
// an update compares the key with its children at each level it moves down (up to 10
// levels for 1024 points): each such level reads the left child, then the right child,
// from the single read port of the slot memories, and compares; an id out of range goes
// straight to the result
// an init writes n slots, n the heap size held to 1 .. HEAP_DEPTH, one slot per cycle
// after reset a clearing pass writes all HEAP_DEPTH slots, with s_axis_tready low; cfg
// writes are taken throughout
// one request in flight; the result sits in an output register, so the next beat is
// taken while the previous result is still stalled on m_axis

module indexed_max_heap_decrease_key_unit #(
  parameter int unsigned HEAP_DEPTH = imhdk_pkg::HEAP_DEPTH_DEF,
  parameter int unsigned KEY_BITS   = imhdk_pkg::KEY_BITS_DEF
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  // heap_size
  input  logic                             cfg_we_i,
  input  logic [imhdk_pkg::CFG_W-1:0]      cfg_wdata_i,
  // point_id, new_key
  input  logic                             s_axis_tvalid,
  output logic                             s_axis_tready,
  input  logic [imhdk_pkg::IN_DATA_W-1:0]  s_axis_tdata,
  // req_type
  input  logic [0:0]                       s_axis_tuser,
  // top_id, top_key
  output logic                             m_axis_tvalid,
  input  logic                             m_axis_tready,
  output logic [imhdk_pkg::OUT_DATA_W-1:0] m_axis_tdata,
  // bad_request
  output logic [0:0]                       m_axis_tuser
);

  import imhdk_pkg::*;

  localparam int unsigned SW = $clog2(HEAP_DEPTH);

  logic [CFG_W-1:0] heap_size_q;

  heap_req_t req;
  heap_res_t res;
  logic      req_ready, res_valid, res_ready;

  // memory ports
  logic                key_we;
  logic [SW-1:0]       key_waddr;
  logic [KEY_BITS-1:0] key_wdata, key_rdata;
  logic                sp_we;
  logic [SW-1:0]       sp_waddr, sp_wdata, sp_rdata, slot_raddr;
  logic                ps_we;
  logic [SW-1:0]       ps_waddr, ps_wdata, ps_raddr, ps_rdata;

  // output register
  logic                  out_valid_q;
  logic [OUT_DATA_W-1:0] out_data_q;
  logic                  out_bad_q;

  // config register, sampled as each request is taken
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      heap_size_q <= HEAP_SIZE_RST;
    end else if (cfg_we_i) begin
      heap_size_q <= cfg_wdata_i;
    end
  end

  // unpack the input beat
  assign req.init     = s_axis_tuser[0];
  assign req.point_id = s_axis_tdata[ID_W-1:0];
  assign req.new_key  = s_axis_tdata[ID_W+KEY_IO_W-1:ID_W];

  assign s_axis_tready = req_ready;

  // the sequencer may hand over a result whenever the output stage is free
  assign res_ready = !out_valid_q || m_axis_tready;

  imhdk_ctrl #(
    .HEAP_DEPTH (HEAP_DEPTH),
    .KEY_BITS   (KEY_BITS)
  ) u_ctrl (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .heap_size_i  (heap_size_q),
    .req_valid_i  (s_axis_tvalid),
    .req_ready_o  (req_ready),
    .req_i        (req),
    .res_valid_o  (res_valid),
    .res_ready_i  (res_ready),
    .res_o        (res),
    .key_we_o     (key_we),
    .key_waddr_o  (key_waddr),
    .key_wdata_o  (key_wdata),
    .key_rdata_i  (key_rdata),
    .sp_we_o      (sp_we),
    .sp_waddr_o   (sp_waddr),
    .sp_wdata_o   (sp_wdata),
    .sp_rdata_i   (sp_rdata),
    .slot_raddr_o (slot_raddr),
    .ps_we_o      (ps_we),
    .ps_waddr_o   (ps_waddr),
    .ps_wdata_o   (ps_wdata),
    .ps_raddr_o   (ps_raddr),
    .ps_rdata_i   (ps_rdata)
  );

  // key held in each slot
  imhdk_ram #(
    .WIDTH (KEY_BITS),
    .DEPTH (HEAP_DEPTH)
  ) u_slot_key (
    .clk_i   (clk_i),
    .we_i    (key_we),
    .waddr_i (key_waddr),
    .wdata_i (key_wdata),
    .raddr_i (slot_raddr),
    .rdata_o (key_rdata)
  );

  // point held in each slot
  imhdk_ram #(
    .WIDTH (SW),
    .DEPTH (HEAP_DEPTH)
  ) u_slot_point (
    .clk_i   (clk_i),
    .we_i    (sp_we),
    .waddr_i (sp_waddr),
    .wdata_i (sp_wdata),
    .raddr_i (slot_raddr),
    .rdata_o (sp_rdata)
  );

  // slot of each point
  imhdk_ram #(
    .WIDTH (SW),
    .DEPTH (HEAP_DEPTH)
  ) u_point_slot (
    .clk_i   (clk_i),
    .we_i    (ps_we),
    .waddr_i (ps_waddr),
    .wdata_i (ps_wdata),
    .raddr_i (ps_raddr),
    .rdata_o (ps_rdata)
  );

  // result beat register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (res_valid && res_ready) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_valid && res_ready) begin
      out_data_q <= OUT_DATA_W'({res.top_key, res.top_id});
      out_bad_q  <= res.bad;
    end
  end

  assign m_axis_tvalid   = out_valid_q;
  assign m_axis_tdata    = out_data_q;
  assign m_axis_tuser[0] = out_bad_q;

endmodule

/* rtl/imhdk_checker.sv */
`timescale 1ns / 1ps

module imhdk_checker (
  input logic                             clk_i,
  input logic                             rst_ni,
  input logic                             s_axis_tvalid,
  input logic                             s_axis_tready,
  input logic                             m_axis_tvalid,
  input logic                             m_axis_tready,
  input logic [imhdk_pkg::OUT_DATA_W-1:0] m_axis_tdata,
  input logic [0:0]                       m_axis_tuser
);

  // a stalled result beat stays up
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
    else $error("result beat dropped while stalled");

  // and keeps its payload
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> $stable(m_axis_tdata) && $stable(m_axis_tuser))
    else $error("result payload changed while stalled");

  // one request at a time: ready falls after every accepted beat
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
    else $error("second request taken while one is in flight");

  // clearing pass after reset blocks requests
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(rst_ni) |-> !s_axis_tready)
    else $error("request taken before the clearing pass");

endmodule

bind indexed_max_heap_decrease_key_unit imhdk_checker u_imhdk_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tuser  (m_axis_tuser)
);
